@@ sv/fsnr_pkg.sv @@
// Shared types and constants for the frame store with normalized readout.
// Holds the item and result payloads, opcodes, register indexes, controller
// states and the command/status bundles between controller and datapath.
package fsnr_pkg;

    localparam int OP_W        = 3;
    localparam int COORD_W     = 11;
    localparam int SIDE_W      = 12;
    localparam int CHAN_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int LANE_W      = 2;
    localparam int AREA_W      = 24;

    localparam logic [OP_W-1:0] OP_WRITE_COLOUR = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE_DEPTH  = 3'd1;
    localparam logic [OP_W-1:0] OP_READ_COLOUR  = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_DEPTH   = 3'd3;
    localparam logic [OP_W-1:0] OP_SCAN         = 3'd4;
    localparam logic [OP_W-1:0] OP_NORM_READ    = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 12'd256;
    localparam logic [CHAN_W-1:0] ONE_Q88    = 16'd256;
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 16'hFFFF;

    localparam logic [LANE_W-1:0] LANE_RED   = 2'd0;
    localparam logic [LANE_W-1:0] LANE_GREEN = 2'd1;
    localparam logic [LANE_W-1:0] LANE_BLUE  = 2'd2;
    localparam logic [LANE_W-1:0] LANE_GREY  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  depth;
    } item_t;

    typedef struct packed {
        logic               status;
        logic [CHAN_W-1:0]  read_red;
        logic [CHAN_W-1:0]  read_green;
        logic [CHAN_W-1:0]  read_blue;
        logic [CHAN_W-1:0]  read_depth;
        logic [BYTE_W-1:0]  red_byte;
        logic [BYTE_W-1:0]  green_byte;
        logic [BYTE_W-1:0]  blue_byte;
        logic [BYTE_W-1:0]  grey_byte;
        logic [CHAN_W-1:0]  colour_peak_out;
        logic [CHAN_W-1:0]  depth_low_out;
        logic [CHAN_W-1:0]  depth_high_out;
    } result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOCATE,
        ST_WRITE,
        ST_READ,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              capture;
        logic              locate;
        logic              clear;
        logic              ram_write;
        logic              ram_read;
        logic              scan_step;
        logic              scan_commit;
        logic              div_start;
        logic [LANE_W-1:0] div_lane;
        logic              load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ok;
        logic            clear_last;
        logic            scan_last;
        logic            div_done;
        logic            result_free;
    } ctrl_sts_t;

endpackage

@@ sv/fsnr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsnr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/fsnr_div.sv @@
// Restoring divider giving min(255, floor(num*255/den)), one bit a cycle.
// Depends on fsnr_pkg for channel and byte widths.
module fsnr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fsnr_pkg::CHAN_W-1:0] num,
    input  logic [fsnr_pkg::CHAN_W-1:0] den,
    output logic                        done,
    output logic [fsnr_pkg::BYTE_W-1:0] quotient
);
    import fsnr_pkg::*;

    localparam int REM_W = CHAN_W + BYTE_W;

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [REM_W-1:0]  dsh_reg, dsh_next;
    logic [BYTE_W:0]   q_reg, q_next;
    logic [3:0]        step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // num*255 as num*256 - num
            rem_next  = {num, {BYTE_W{1'b0}}} - REM_W'(num);
            dsh_next  = {den, {BYTE_W{1'b0}}};
            q_next    = '0;
            step_next = 4'(BYTE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[BYTE_W-1:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[BYTE_W-1:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            if (step_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    // saturate when the quotient reaches 256 or more
    assign quotient = q_reg[BYTE_W] ? {BYTE_W{1'b1}} : q_reg[BYTE_W-1:0];

endmodule

@@ sv/fsnr_datapath.sv @@
// Datapath: frame size registers, pixel store, scan accumulators, divider
// and result register. Depends on fsnr_pkg, fsnr_ram and fsnr_div.
module fsnr_datapath #(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_SIDE   = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [fsnr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fsnr_pkg::SIDE_W-1:0]      cfg_data,
    input  fsnr_pkg::item_t                  item,
    output fsnr_pkg::result_t                result,
    output logic                             result_valid,
    input  logic                             result_stall,
    input  fsnr_pkg::ctrl_cmd_t              cmd,
    output fsnr_pkg::ctrl_sts_t              sts
);
    import fsnr_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [AREA_W-1:0] MAX_AREA   = AREA_W'(MAX_PIXELS);
    localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(MAX_SIDE);
    localparam logic [AW-1:0]     LAST_ADDR  = AW'(MAX_PIXELS - 1);
    localparam int COLOUR_W = 3 * CHAN_W;

    logic [SIDE_W-1:0] width_reg, height_reg;
    logic [SIDE_W-1:0] cfg_side;

    item_t             item_reg;
    logic [AW-1:0]     idx_reg;
    logic              ok_reg;
    logic [AW-1:0]     scan_last_reg;
    logic [AW-1:0]     scan_addr_reg;
    logic              scan_pipe_reg;
    logic [AW-1:0]     clear_addr_reg;

    logic [CHAN_W-1:0] peak_reg, low_reg, high_reg;
    logic [CHAN_W-1:0] pk_acc_reg, lo_acc_reg, hi_acc_reg;
    logic [CHAN_W-1:0] pk_upd, lo_upd, hi_upd;

    logic [BYTE_W-1:0] red_byte_reg, green_byte_reg, blue_byte_reg, grey_byte_reg;

    result_t           result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    logic [AREA_W-1:0] pixel_idx;
    logic [AREA_W-1:0] area;
    logic [AREA_W-1:0] scan_count;
    logic              in_frame;

    logic                colour_we, depth_we, ram_re;
    logic [AW-1:0]       waddr, raddr;
    logic [COLOUR_W-1:0] colour_wdata, colour_rdata;
    logic [CHAN_W-1:0]   depth_wdata, depth_rdata;
    logic [CHAN_W-1:0]   rd_red, rd_green, rd_blue;

    logic [CHAN_W-1:0] colour_den, depth_range, grey_num;
    logic [CHAN_W-1:0] div_num, div_den;
    logic              div_done;
    logic [BYTE_W-1:0] div_q;

    // frame size registers
    always_comb
    begin
        cfg_side = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_side = SIDE_W'(1);
        end
        else if (cfg_data > SIDE_LIMIT)
        begin
            cfg_side = SIDE_LIMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIDE_RESET;
            height_reg <= SIDE_RESET;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                width_reg <= cfg_side;
            end
            else if (cfg_index == REG_FRAME_HEIGHT)
            begin
                height_reg <= cfg_side;
            end
        end
    end

    // location and scan extent
    assign pixel_idx  = AREA_W'(item_reg.y) * AREA_W'(width_reg) + AREA_W'(item_reg.x);
    assign in_frame   = (SIDE_W'(item_reg.x) < width_reg) && (SIDE_W'(item_reg.y) < height_reg)
                        && (pixel_idx < MAX_AREA);
    assign area       = AREA_W'(width_reg) * AREA_W'(height_reg);
    assign scan_count = (area < MAX_AREA) ? area : MAX_AREA;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.locate)
        begin
            idx_reg       <= pixel_idx[AW-1:0];
            ok_reg        <= in_frame;
            scan_last_reg <= AW'(scan_count - AREA_W'(1));
        end
    end

    // pixel store
    assign rd_red   = colour_rdata[CHAN_W-1:0];
    assign rd_green = colour_rdata[2*CHAN_W-1:CHAN_W];
    assign rd_blue  = colour_rdata[COLOUR_W-1:2*CHAN_W];

    always_comb
    begin
        colour_we    = 1'b0;
        depth_we     = 1'b0;
        waddr        = idx_reg;
        colour_wdata = {item_reg.blue, item_reg.green, item_reg.red};
        depth_wdata  = item_reg.depth;
        if (cmd.clear)
        begin
            colour_we    = 1'b1;
            depth_we     = 1'b1;
            waddr        = clear_addr_reg;
            colour_wdata = '0;
            depth_wdata  = '0;
        end
        else if (cmd.ram_write)
        begin
            colour_we = (item_reg.operation == OP_WRITE_COLOUR);
            depth_we  = (item_reg.operation == OP_WRITE_DEPTH);
        end
    end

    assign ram_re = cmd.ram_read | cmd.scan_step;
    assign raddr  = cmd.scan_step ? scan_addr_reg : idx_reg;

    fsnr_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (MAX_PIXELS)
    ) u_colour_ram (
        .clk   (clk),
        .we    (colour_we),
        .waddr (waddr),
        .wdata (colour_wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (colour_rdata)
    );

    fsnr_ram #(
        .WIDTH (CHAN_W),
        .DEPTH (MAX_PIXELS)
    ) u_depth_ram (
        .clk   (clk),
        .we    (depth_we),
        .waddr (waddr),
        .wdata (depth_wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (depth_rdata)
    );

    // scan walk and accumulators
    always_comb
    begin
        pk_upd = pk_acc_reg;
        lo_upd = lo_acc_reg;
        hi_upd = hi_acc_reg;
        if (scan_pipe_reg)
        begin
            if (rd_red > pk_upd)
            begin
                pk_upd = rd_red;
            end
            if (rd_green > pk_upd)
            begin
                pk_upd = rd_green;
            end
            if (rd_blue > pk_upd)
            begin
                pk_upd = rd_blue;
            end
            if (depth_rdata < lo_upd)
            begin
                lo_upd = depth_rdata;
            end
            if (depth_rdata > hi_upd)
            begin
                hi_upd = depth_rdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            scan_addr_reg  <= '0;
            scan_pipe_reg  <= 1'b0;
            peak_reg       <= '0;
            low_reg        <= CHAN_MAX;
            high_reg       <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
            end
            scan_pipe_reg <= cmd.scan_step;
            if (cmd.locate)
            begin
                scan_addr_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_addr_reg <= scan_addr_reg + AW'(1);
            end
            if (cmd.scan_commit)
            begin
                peak_reg <= pk_upd;
                low_reg  <= lo_upd;
                high_reg <= hi_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.locate)
        begin
            pk_acc_reg <= '0;
            lo_acc_reg <= CHAN_MAX;
            hi_acc_reg <= '0;
        end
        else
        begin
            pk_acc_reg <= pk_upd;
            lo_acc_reg <= lo_upd;
            hi_acc_reg <= hi_upd;
        end
    end

    // normalization operands
    assign colour_den  = (peak_reg != '0) ? peak_reg : ONE_Q88;
    assign depth_range = (high_reg > low_reg) ? (high_reg - low_reg) : ONE_Q88;
    assign grey_num    = (depth_rdata > low_reg) ? (depth_rdata - low_reg) : '0;

    always_comb
    begin
        case (cmd.div_lane)
            LANE_RED:
            begin
                div_num = rd_red;
                div_den = colour_den;
            end
            LANE_GREEN:
            begin
                div_num = rd_green;
                div_den = colour_den;
            end
            LANE_BLUE:
            begin
                div_num = rd_blue;
                div_den = colour_den;
            end
            LANE_GREY:
            begin
                div_num = grey_num;
                div_den = depth_range;
            end
            default:
            begin
                div_num = '0;
                div_den = ONE_Q88;
            end
        endcase
    end

    fsnr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            case (cmd.div_lane)
                LANE_RED:   red_byte_reg   <= div_q;
                LANE_GREEN: green_byte_reg <= div_q;
                LANE_BLUE:  blue_byte_reg  <= div_q;
                LANE_GREY:  grey_byte_reg  <= div_q;
                default:    grey_byte_reg  <= div_q;
            endcase
        end
    end

    // result register
    always_comb
    begin
        result_next                 = '0;
        result_next.colour_peak_out = peak_reg;
        result_next.depth_low_out   = low_reg;
        result_next.depth_high_out  = high_reg;
        case (item_reg.operation)
            OP_WRITE_COLOUR, OP_WRITE_DEPTH:
            begin
                result_next.status = !ok_reg;
            end
            OP_READ_COLOUR:
            begin
                result_next.status = !ok_reg;
                if (ok_reg)
                begin
                    result_next.read_red   = rd_red;
                    result_next.read_green = rd_green;
                    result_next.read_blue  = rd_blue;
                end
            end
            OP_READ_DEPTH:
            begin
                result_next.status = !ok_reg;
                if (ok_reg)
                begin
                    result_next.read_depth = depth_rdata;
                end
            end
            OP_NORM_READ:
            begin
                result_next.status = !ok_reg;
                if (ok_reg)
                begin
                    result_next.red_byte   = red_byte_reg;
                    result_next.green_byte = green_byte_reg;
                    result_next.blue_byte  = blue_byte_reg;
                    result_next.grey_byte  = grey_byte_reg;
                end
            end
            default:
            begin
                result_next.status = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign sts.op          = item_reg.operation;
    assign sts.ok          = ok_reg;
    assign sts.clear_last  = (clear_addr_reg == LAST_ADDR);
    assign sts.scan_last   = (scan_addr_reg == scan_last_reg);
    assign sts.div_done    = div_done;
    assign sts.result_free = !result_valid_reg || !result_stall;

endmodule

@@ sv/fsnr_ctrl.sv @@
// Controller state machine: clearing pass, item sequencing, scan walk and
// divider lanes. Depends on fsnr_pkg.
module fsnr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    output fsnr_pkg::ctrl_cmd_t cmd,
    input  fsnr_pkg::ctrl_sts_t sts
);
    import fsnr_pkg::*;

    state_t            state_reg, state_next;
    logic [LANE_W-1:0] lane_reg, lane_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            lane_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lane_reg  <= lane_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        lane_next    = lane_reg;
        cmd          = '0;
        cmd.div_lane = lane_reg;
        item_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOCATE;
                end
            end
            ST_LOCATE:
            begin
                cmd.locate = 1'b1;
                state_next = ST_FINISH;
                if (sts.op == OP_SCAN)
                begin
                    state_next = ST_SCAN;
                end
                else if (sts.op inside {OP_WRITE_COLOUR, OP_WRITE_DEPTH})
                begin
                    state_next = ST_WRITE;
                end
                else if (sts.op inside {OP_READ_COLOUR, OP_READ_DEPTH, OP_NORM_READ})
                begin
                    state_next = ST_READ;
                end
            end
            ST_WRITE:
            begin
                cmd.ram_write = sts.ok;
                state_next    = ST_FINISH;
            end
            ST_READ:
            begin
                cmd.ram_read = sts.ok;
                lane_next    = LANE_RED;
                if (sts.ok && (sts.op == OP_NORM_READ))
                begin
                    state_next = ST_DIV_START;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_SCAN_TAIL;
                end
            end
            ST_SCAN_TAIL:
            begin
                cmd.scan_commit = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    if (lane_reg == LANE_GREY)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        lane_next  = lane_reg + LANE_W'(1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_FINISH:
            begin
                if (sts.result_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/frame_store_with_normalized_readout_core.sv @@
// Frame store with min/max normalized readout, top level.
// Depends on fsnr_pkg, fsnr_ctrl and fsnr_datapath.
//
// Items enter on item/item_valid/item_stall and each gives exactly one result
// beat on result/result_valid/result_stall. Frame width and height are set
// through cfg_write_en/cfg_index/cfg_data; the user must set them only while
// the block is idle, which the block itself does not enforce. One item is
// worked at a time; the pixel store is a single-port-read RAM and the
// sequencer steps through it. States after the locate step, to result load:
//   write, read or out-of-frame: write or read, finish; unknown code: finish
//   normalized read: read, then four passes of the shared bit-serial
//     divider (three colour bytes, then grey), then finish
//   scan: one pixel a cycle, N = min(width*height, MAX_PIXELS); tail; finish
// The next item is taken while the last result still waits in the output
// register. A stalled result holds; the item then finishing its work waits
// for the register to drain.
// After reset the store is swept to zero, one entry a cycle, over all MAX_PIXELS
// entries; item_stall stays high during the sweep, config writes are taken.
module frame_store_with_normalized_readout_core #(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_SIDE   = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [fsnr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fsnr_pkg::SIDE_W-1:0]      cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  fsnr_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output fsnr_pkg::result_t                result
);
    import fsnr_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    fsnr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cmd        (cmd),
        .sts        (sts)
    );

    fsnr_datapath #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_SIDE   (MAX_SIDE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    a_load_needs_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> sts.result_free)
        else $error("result loaded over an undelivered beat");

    a_capture_then_locate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.locate)
        else $error("accepted item not located in the next cycle");

    a_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ram_write |-> (sts.ok && !cmd.clear))
        else $error("store write outside frame or during clearing");

    a_divider_single: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> !cmd.div_start)
        else $error("divider restarted while finishing");

endmodule

@@ tb/sv/tb_frame_store_with_normalized_readout_core.sv @@
// Self-checking testbench for frame_store_with_normalized_readout_core.
// Drives directed and random pixel, scan and normalized-read beats under random
// handshake gaps and checks every result against a predictor or a directed expected result; needs fsnr_pkg.
`timescale 1ns / 100ps

module tb_frame_store_with_normalized_readout_core;

    import fsnr_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int PIXELS      = 65536;
    localparam int SIDE_MAX    = 2048;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 4;
    localparam int END_CYCLES  = 100;
    localparam int PRINT_CAP   = 200;

    localparam logic [OP_W-1:0]        OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0]        OP_UNUSED_B = 3'd7;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } stim_row_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [SIDE_W-1:0]      cfg_data     = '0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    item_t                  item         = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;

    bit [63:0]         pix_mem [PIXELS];
    int unsigned       frame_w    = SIDE_RESET;
    int unsigned       frame_h    = SIDE_RESET;
    logic [CHAN_W-1:0] peak_q     = '0;
    logic [CHAN_W-1:0] depth_lo_q = CHAN_MAX;
    logic [CHAN_W-1:0] depth_hi_q = '0;

    result_t     expected_results [$];
    stim_row_t   directed_rows [$];
    logic [21:0] recent_xy [$];
    int          burst_left [2];
    int          drain_hold;
    int          scans_left;
    int          op_count [8];
    int          outside_count;
    int          phases_run;
    int          results_checked;
    int          errors;
    int          cycle_count;

    frame_store_with_normalized_readout_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[frame_store_with_normalized_readout_core] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_CAP)
            $display("MISMATCH %s", msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s: got %h, expected %h",
                                      results_checked, name, got, want));
    endtask

    task automatic check_result(input result_t got, input result_t want);
        check_field("status", got.status, want.status);
        check_field("read_red", got.read_red, want.read_red);
        check_field("read_green", got.read_green, want.read_green);
        check_field("read_blue", got.read_blue, want.read_blue);
        check_field("read_depth", got.read_depth, want.read_depth);
        check_field("red_byte", got.red_byte, want.red_byte);
        check_field("green_byte", got.green_byte, want.green_byte);
        check_field("blue_byte", got.blue_byte, want.blue_byte);
        check_field("grey_byte", got.grey_byte, want.grey_byte);
        check_field("colour_peak_out", got.colour_peak_out, want.colour_peak_out);
        check_field("depth_low_out", got.depth_low_out, want.depth_low_out);
        check_field("depth_high_out", got.depth_high_out, want.depth_high_out);
    endtask

    function automatic int draw_idle(input int side);
        if (burst_left[side] > 0)
        begin
            burst_left[side]--;
            return 0;
        end
        if ($urandom_range(11, 0) == 0)
        begin
            burst_left[side] = $urandom_range(30, 8);
            return 0;
        end
        return $urandom_range(14, 0);
    endfunction

    function automatic logic [CHAN_W-1:0] draw_chan();
        case ($urandom_range(7, 0))
            0: return '0;
            1: return CHAN_MAX;
            2: return CHAN_W'($urandom_range(16'h01FF, 0));
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] scale_to_byte(input logic [CHAN_W-1:0] num,
                                                        input logic [CHAN_W-1:0] den);
        logic [31:0] q;
        q = ({16'd0, num} * 32'd255) / {16'd0, den};
        return (q > 32'd255) ? 8'd255 : q[BYTE_W-1:0];
    endfunction

    function automatic result_t predict_pixel_op(input item_t it);
        result_t           res;
        int unsigned       idx;
        int unsigned       n;
        int unsigned       k;
        bit                in_frame;
        logic [63:0]       px;
        logic [CHAN_W-1:0] pk;
        logic [CHAN_W-1:0] lo;
        logic [CHAN_W-1:0] hi;
        logic [CHAN_W-1:0] span;
        logic [CHAN_W-1:0] dv;
        res = '0;
        in_frame = (it.x < frame_w) && (it.y < frame_h);
        idx = it.y * frame_w + it.x;
        if (idx >= PIXELS)
            in_frame = 1'b0;
        case (it.operation)
            OP_WRITE_COLOUR, OP_WRITE_DEPTH, OP_READ_COLOUR, OP_READ_DEPTH, OP_NORM_READ:
            begin
                if (!in_frame)
                begin
                    res.status = 1'b1;
                    outside_count++;
                end
                else
                begin
                    px = pix_mem[idx];
                    case (it.operation)
                        OP_WRITE_COLOUR: pix_mem[idx] = {px[63:48], it.blue, it.green, it.red};
                        OP_WRITE_DEPTH:  pix_mem[idx] = {it.depth, px[47:0]};
                        OP_READ_COLOUR:
                        begin
                            res.read_red   = px[15:0];
                            res.read_green = px[31:16];
                            res.read_blue  = px[47:32];
                        end
                        OP_READ_DEPTH:   res.read_depth = px[63:48];
                        default:
                        begin
                            pk   = (peak_q != '0) ? peak_q : ONE_Q88;
                            span = (depth_hi_q > depth_lo_q) ? depth_hi_q - depth_lo_q
                                                             : ONE_Q88;
                            dv   = px[63:48];
                            res.red_byte   = scale_to_byte(px[15:0], pk);
                            res.green_byte = scale_to_byte(px[31:16], pk);
                            res.blue_byte  = scale_to_byte(px[47:32], pk);
                            res.grey_byte  = (dv > depth_lo_q)
                                           ? scale_to_byte(dv - depth_lo_q, span) : '0;
                        end
                    endcase
                end
            end
            OP_SCAN:
            begin
                n = frame_w * frame_h;
                if (n > PIXELS)
                    n = PIXELS;
                pk = '0;
                lo = CHAN_MAX;
                hi = '0;
                for (k = 0; k < n; k++)
                begin
                    px = pix_mem[k];
                    if (px[15:0] > pk)  pk = px[15:0];
                    if (px[31:16] > pk) pk = px[31:16];
                    if (px[47:32] > pk) pk = px[47:32];
                    if (px[63:48] > hi) hi = px[63:48];
                    if (px[63:48] < lo) lo = px[63:48];
                end
                peak_q     = pk;
                depth_lo_q = lo;
                depth_hi_q = hi;
            end
            default: ;
        endcase
        res.colour_peak_out = peak_q;
        res.depth_low_out   = depth_lo_q;
        res.depth_high_out  = depth_hi_q;
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [SIDE_W-1:0] data);
        int unsigned side;
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        side = (data == '0) ? 1 : (data > SIDE_MAX) ? SIDE_MAX : data;
        if (index == REG_FRAME_WIDTH)
            frame_w = side;
        else if (index == REG_FRAME_HEIGHT)
            frame_h = side;
    endtask

    task automatic offer_item(input item_t it, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = draw_idle(0);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        predicted = predict_pixel_op(it);
        expected_results.push_back(typed ? want : predicted);
        op_count[it.operation]++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic draw_item(input int scan_pct, output item_t it);
        int          roll;
        int          pick;
        int unsigned y_top;
        it       = '0;
        it.red   = draw_chan();
        it.green = draw_chan();
        it.blue  = draw_chan();
        it.depth = draw_chan();
        roll = $urandom_range(99, 0);
        if (roll < scan_pct && scans_left > 0)
        begin
            it.operation = OP_SCAN;
            scans_left--;
        end
        else
        begin
            roll = $urandom_range(99, 0);
            if (roll < 28)      it.operation = OP_WRITE_COLOUR;
            else if (roll < 50) it.operation = OP_WRITE_DEPTH;
            else if (roll < 60) it.operation = OP_READ_COLOUR;
            else if (roll < 70) it.operation = OP_READ_DEPTH;
            else if (roll < 96) it.operation = OP_NORM_READ;
            else                it.operation = $urandom_range(1, 0) ? OP_UNUSED_A : OP_UNUSED_B;
        end
        if (recent_xy.size() != 0 && $urandom_range(9, 0) < 4)
        begin
            pick = $urandom_range(recent_xy.size() - 1, 0);
            it.x = recent_xy[pick][21:11];
            it.y = recent_xy[pick][10:0];
        end
        else if ($urandom_range(9, 0) == 0)
        begin
            it.x = COORD_W'($urandom);
            it.y = COORD_W'($urandom);
        end
        else
        begin
            y_top = frame_h - 1;
            if (frame_w * frame_h > PIXELS && PIXELS / frame_w + 1 < y_top)
                y_top = PIXELS / frame_w + 1;
            it.x = COORD_W'($urandom_range(frame_w - 1, 0));
            it.y = COORD_W'($urandom_range(y_top, 0));
        end
        if (it.operation == OP_WRITE_COLOUR || it.operation == OP_WRITE_DEPTH)
        begin
            recent_xy.push_back({it.x, it.y});
            if (recent_xy.size() > 32)
                void'(recent_xy.pop_front());
        end
    endtask

    task automatic run_phase(input logic [SIDE_W-1:0] w_raw, input logic [SIDE_W-1:0] h_raw,
                             input int count, input int scan_cap, input int scan_pct);
        item_t   it;
        result_t none;
        none = '0;
        drain_results();
        write_reg(REG_FRAME_WIDTH, w_raw);
        write_reg(REG_FRAME_HEIGHT, h_raw);
        scans_left = scan_cap;
        recent_xy.delete();
        phases_run++;
        for (int n = 0; n < count; n++)
        begin
            draw_item(scan_pct, it);
            offer_item(it, 1'b0, none);
        end
    endtask

    function automatic item_t mk_item(input logic [OP_W-1:0] op, input int unsigned x,
                                      input int unsigned y, input logic [CHAN_W-1:0] r,
                                      input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
                                      input logic [CHAN_W-1:0] d);
        item_t it;
        it.operation = op;
        it.x         = COORD_W'(x);
        it.y         = COORD_W'(y);
        it.red       = r;
        it.green     = g;
        it.blue      = b;
        it.depth     = d;
        return it;
    endfunction

    task automatic add_row(input item_t stim, input bit typed, input result_t want);
        stim_row_t row;
        row.stim  = stim;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    always @(negedge clk)
    begin
        if (drain_hold > 0)
        begin
            result_stall <= 1'b1;
            drain_hold--;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && result_valid === 1'b1 && !result_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("beat %0d arrived with nothing expected: %h",
                                          results_checked, result));
            else
            begin
                want = expected_results.pop_front();
                check_result(result, want);
            end
            results_checked++;
            if (results_checked == HOLD_AT)
                drain_hold = HOLD_CYCLES;
            else
                drain_hold = draw_idle(1);
        end
    end

    initial
    begin
        result_t blank;
        result_t outside;
        result_t none;
        none                  = '0;
        blank                 = '0;
        blank.depth_low_out   = CHAN_MAX;
        outside               = blank;
        outside.status        = 1'b1;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        add_row(mk_item(OP_READ_COLOUR, 0, 0, 0, 0, 0, 0), 1'b1, blank);
        add_row(mk_item(OP_READ_DEPTH, 255, 255, 0, 0, 0, 0), 1'b1, blank);
        add_row(mk_item(OP_NORM_READ, 0, 0, 0, 0, 0, 0), 1'b1, blank);
        add_row(mk_item(OP_READ_COLOUR, 256, 0, 0, 0, 0, 0), 1'b1, outside);
        add_row(mk_item(OP_WRITE_DEPTH, 0, 256, 0, 0, 0, 16'h1234), 1'b1, outside);
        add_row(mk_item(OP_NORM_READ, 2047, 2047, CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX),
                1'b1, outside);
        add_row(mk_item(OP_WRITE_COLOUR, 0, 0, CHAN_MAX, CHAN_MAX, CHAN_MAX, 0), 1'b1, blank);
        add_row(mk_item(OP_WRITE_DEPTH, 0, 0, 0, 0, 0, CHAN_MAX), 1'b1, blank);
        add_row(mk_item(OP_WRITE_COLOUR, 255, 255, 16'h0100, 16'h0080, 16'h0001, 0),
                1'b0, none);
        add_row(mk_item(OP_WRITE_DEPTH, 255, 255, 0, 0, 0, 16'h0000), 1'b0, none);
        add_row(mk_item(OP_WRITE_DEPTH, 1, 0, 0, 0, 0, 16'h8000), 1'b0, none);
        add_row(mk_item(OP_WRITE_COLOUR, 1, 0, 16'h7FFF, 16'h0000, 16'h4000, 0), 1'b0, none);
        add_row(mk_item(OP_READ_COLOUR, 0, 0, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_item(OP_READ_DEPTH, 0, 0, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_item(OP_NORM_READ, 0, 0, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_item(OP_NORM_READ, 1, 0, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_item(OP_SCAN, 0, 0, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_item(OP_NORM_READ, 255, 255, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_item(OP_NORM_READ, 1, 0, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_item(OP_NORM_READ, 0, 0, 0, 0, 0, 0), 1'b0, none);
        add_row(mk_item(OP_UNUSED_A, 3, 3, CHAN_MAX, 1, 2, 3), 1'b0, none);
        add_row(mk_item(OP_UNUSED_B, 2047, 2047, 0, CHAN_MAX, 0, CHAN_MAX), 1'b0, none);
        add_row(mk_item(OP_WRITE_COLOUR, 300, 5, 1, 2, 3, 0), 1'b0, none);
        add_row(mk_item(OP_READ_COLOUR, 255, 0, 0, 0, 0, 0), 1'b0, none);

        phases_run = 1;
        foreach (directed_rows[i])
            offer_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

        run_phase(12'd4, 12'd4, 150, 20, 12);
        run_phase(12'd0, 12'd0, 40, 10, 15);
        run_phase(12'd4095, 12'd2049, 60, 2, 5);
        run_phase(12'd2048, 12'd1, 60, 6, 10);
        run_phase(12'd1, 12'd2048, 60, 6, 10);
        drain_results();
        write_reg(REG_SPARE_A, SIDE_W'($urandom));
        write_reg(REG_SPARE_B, SIDE_W'($urandom));
        run_phase(12'd7, 12'd9, 150, 20, 12);

        drain_results();
        repeat (END_CYCLES) @(negedge clk);

        $display("Ran %0d items over %0d frame settings: %0d scans, %0d normalized reads, %0d out of frame.",
                 op_count.sum(), phases_run, op_count[OP_SCAN], op_count[OP_NORM_READ],
                 outside_count);
        $display("Checked %0d result beats, %0d mismatches.", results_checked, errors);
        if (errors == 0)
            $display("[frame_store_with_normalized_readout_core] OK");
        else
            $display("[frame_store_with_normalized_readout_core] ERROR");
        $finish;
    end

endmodule
